// ===== rtl/hse_pkg.sv =====
`default_nettype none

package hse_pkg;

    localparam int UPEM_W     = 16;
    localparam int PPEM_W     = 8;
    localparam int AW_W       = 16;
    localparam int DW_W       = 8;
    localparam int BYTE_W     = 8;

    // Scaled numerator 64*ppem*aw + upem/2 stays below 2^30.
    localparam int NUM_W      = 30;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;

    // Predicted width is (quotient + 32) / 64.
    localparam int PRED_W     = NUM_W - 5;
    localparam int S_W        = PRED_W + 1;

    localparam int MAX_BYTES  = 3;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [UPEM_W-1:0] UPEM_RESET = UPEM_W'(2048);

    localparam logic signed [S_W-1:0] SHORT_LO   = S_W'(-139);
    localparam logic signed [S_W-1:0] SHORT_HI   = S_W'(111);
    localparam logic signed [S_W-1:0] SHORT_BIAS = S_W'(139);
    localparam logic signed [S_W-1:0] POS_LO     = S_W'(108);
    localparam logic signed [S_W-1:0] POS_HI     = S_W'(875);
    localparam logic signed [S_W-1:0] NEG_LO     = S_W'(-363);
    localparam logic signed [S_W-1:0] NEG_HI     = S_W'(-108);
    localparam logic signed [S_W-1:0] NEG_BIAS   = S_W'(108);
    localparam logic signed [S_W-1:0] LONG_HI    = S_W'(-364);
    localparam logic signed [S_W-1:0] LONG_BIAS  = S_W'(364);

    localparam logic [BYTE_W-1:0] POS_BASE  = BYTE_W'(251);
    localparam logic [BYTE_W-1:0] NEG_CODE  = BYTE_W'(254);
    localparam logic [BYTE_W-1:0] LONG_CODE = BYTE_W'(255);

    typedef struct packed {
        logic [PPEM_W-1:0] pixels_per_em;
        logic [AW_W-1:0]   adv_width;
        logic [DW_W-1:0]   device_width;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last_byte;
    } out_item_t;

    // Up to three code bytes written into the output queue in one cycle.
    typedef struct packed {
        logic [1:0]           count;
        out_item_t [MAX_BYTES-1:0] item;
    } fifo_wr_t;

endpackage

`default_nettype wire

// ===== rtl/hse_divider.sv =====
`default_nettype none

module hse_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [hse_pkg::NUM_W-1:0]    in_num,
    input  wire logic [hse_pkg::UPEM_W-1:0]   in_div,
    input  wire logic [hse_pkg::DW_W-1:0]     in_tag,
    output logic                              out_valid,
    output logic [hse_pkg::NUM_W-1:0]         out_quot,
    output logic [hse_pkg::DW_W-1:0]          out_tag
);

    localparam int NS = hse_pkg::DIV_STAGES;

    // Index 0 is the input side, index k+1 the register of stage k.
    logic [NS:0]                     v_w;
    logic [hse_pkg::NUM_W-1:0]       work_w [NS+1];
    logic [hse_pkg::UPEM_W-1:0]      rem_w  [NS+1];
    logic [hse_pkg::UPEM_W-1:0]      div_w  [NS+1];
    logic [hse_pkg::DW_W-1:0]        tag_w  [NS+1];

    logic [NS-1:0]                   valid_reg;
    logic [hse_pkg::NUM_W-1:0]       work_reg  [NS];
    logic [hse_pkg::UPEM_W-1:0]      rem_reg   [NS];
    logic [hse_pkg::UPEM_W-1:0]      div_reg   [NS];
    logic [hse_pkg::DW_W-1:0]        tag_reg   [NS];
    logic [hse_pkg::NUM_W-1:0]       work_next [NS];
    logic [hse_pkg::UPEM_W-1:0]      rem_next  [NS];

    assign v_w[0]    = in_valid;
    assign work_w[0] = in_num;
    assign rem_w[0]  = '0;
    assign div_w[0]  = in_div;
    assign tag_w[0]  = in_tag;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [hse_pkg::UPEM_W:0]   trial;
        logic [hse_pkg::UPEM_W-1:0] rem_t;
        logic [hse_pkg::NUM_W-1:0]  work_t;

        // The quotient bits shift into the low end of the word while the
        // numerator bits leave at the top.
        always_comb
        begin
            rem_t  = rem_w[k];
            work_t = work_w[k];
            trial  = '0;
            for (int j = 0; j < hse_pkg::DIV_STEP; j++)
            begin
                trial  = {rem_t, work_t[hse_pkg::NUM_W-1]};
                work_t = {work_t[hse_pkg::NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, div_w[k]})
                begin
                    trial     = trial - {1'b0, div_w[k]};
                    work_t[0] = 1'b1;
                end
                rem_t = trial[hse_pkg::UPEM_W-1:0];
            end
            rem_next[k]  = rem_t;
            work_next[k] = work_t;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            work_reg[k] <= work_next[k];
            rem_reg[k]  <= rem_next[k];
            div_reg[k]  <= div_w[k];
            tag_reg[k]  <= tag_w[k];
        end

        assign v_w[k+1]    = valid_reg[k];
        assign work_w[k+1] = work_reg[k];
        assign rem_w[k+1]  = rem_reg[k];
        assign div_w[k+1]  = div_reg[k];
        assign tag_w[k+1]  = tag_reg[k];
    end

    assign out_valid = v_w[NS];
    assign out_quot  = work_w[NS];
    assign out_tag   = tag_w[NS];

endmodule

`default_nettype wire

// ===== rtl/hse_byte_fifo.sv =====
`default_nettype none

module hse_byte_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hse_pkg::fifo_wr_t    wr,
    output logic                      pop,
    output logic                      out_valid,
    output hse_pkg::out_item_t        out_item
);

    hse_pkg::out_item_t               mem_reg [hse_pkg::FIFO_DEPTH];
    logic [hse_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [hse_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [hse_pkg::CRED_W-1:0]       count_reg;
    logic [hse_pkg::FIFO_AW-1:0]      wr_ptr_next;
    logic [hse_pkg::FIFO_AW-1:0]      rd_ptr_next;
    logic [hse_pkg::CRED_W-1:0]       count_next;
    logic                             out_valid_reg;
    hse_pkg::out_item_t               out_item_reg;

    assign pop = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + hse_pkg::FIFO_AW'(wr.count);
        rd_ptr_next = rd_ptr_reg + hse_pkg::FIFO_AW'(pop);
        count_next  = count_reg + hse_pkg::CRED_W'(wr.count) - hse_pkg::CRED_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < hse_pkg::MAX_BYTES; k++)
        begin
            if (hse_pkg::CRED_W'(k) < hse_pkg::CRED_W'(wr.count))
            begin
                mem_reg[wr_ptr_reg + hse_pkg::FIFO_AW'(k)] <= wr.item[k];
            end
        end
        out_item_reg <= mem_reg[rd_ptr_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/hdmx_surprise_encoder.sv =====
`default_nettype none

// Channel   | Ports                         | Handshake
// ----------+-------------------------------+------------------------------------
// request   | start, busy, request          | taken when start is high, busy low
// result    | result_valid, result          | one-cycle strobe, cannot be held
// config    | cfg_we, cfg_wdata             | units per em written when cfg_we
//
// A request passes from acceptance to its first code byte through one
// multiply stage, ten divider stages of three quotient bits each, one
// surprise stage, the queue write and the result register. Requests can
// enter every cycle while queue room lasts; each one holds three bytes of
// room from acceptance until its code is queued, so even one-byte codes
// settle a little below one request per cycle. The result side drains one
// byte per cycle, so a stream of requests needing three bytes each is
// limited by that drain. busy rises when the 32-byte queue has no room
// reserved for three more bytes. Reset clears the pipeline valid bits, the
// queue and sets units per em to 2048.

module hdmx_surprise_encoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire hse_pkg::in_item_t           request,
    output logic                             result_valid,
    output hse_pkg::out_item_t               result,
    input  wire logic                        cfg_we,
    input  wire logic [hse_pkg::UPEM_W-1:0]  cfg_wdata
);

    logic                              accept;
    logic [hse_pkg::UPEM_W-1:0]        upem_reg;

    logic                              a_valid_reg;
    logic [hse_pkg::NUM_W-1:0]         a_num_reg;
    logic [hse_pkg::UPEM_W-1:0]        a_div_reg;
    logic [hse_pkg::DW_W-1:0]          a_dw_reg;
    logic [hse_pkg::NUM_W-1:0]         a_num_next;
    logic [hse_pkg::UPEM_W-1:0]        a_div_next;

    logic                              q_valid;
    logic [hse_pkg::NUM_W-1:0]         q_quot;
    logic [hse_pkg::DW_W-1:0]          q_dw;

    logic                              s_valid_reg;
    logic signed [hse_pkg::S_W-1:0]    s_reg;
    logic [hse_pkg::NUM_W:0]           round_sum;
    logic [hse_pkg::PRED_W-1:0]        pred;
    logic signed [hse_pkg::S_W-1:0]    s_next;

    logic signed [hse_pkg::S_W-1:0]    short_val;
    logic signed [hse_pkg::S_W-1:0]    pos_val;
    logic signed [hse_pkg::S_W-1:0]    neg_val;
    logic signed [hse_pkg::S_W-1:0]    long_val;
    hse_pkg::fifo_wr_t                 wr;

    logic                              pop;
    logic [hse_pkg::CRED_W-1:0]        credit_reg;
    logic [hse_pkg::CRED_W-1:0]        credit_next;
    logic [1:0]                        refund;

    assign accept = start && !busy;
    assign busy   = (credit_reg < hse_pkg::CRED_W'(hse_pkg::MAX_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upem_reg <= hse_pkg::UPEM_RESET;
        end
        else if (cfg_we)
        begin
            upem_reg <= cfg_wdata;
        end
    end

    // Stage A: scaled numerator with the rounding half of the divisor.
    always_comb
    begin
        a_div_next = (upem_reg == '0) ? hse_pkg::UPEM_W'(1) : upem_reg;
        a_num_next = {(hse_pkg::NUM_W-6)'(request.pixels_per_em) * request.adv_width,
                      6'b0}
                     + hse_pkg::NUM_W'(a_div_next[hse_pkg::UPEM_W-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        a_num_reg <= a_num_next;
        a_div_reg <= a_div_next;
        a_dw_reg  <= request.device_width;
    end

    hse_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_num    (a_num_reg),
        .in_div    (a_div_reg),
        .in_tag    (a_dw_reg),
        .out_valid (q_valid),
        .out_quot  (q_quot),
        .out_tag   (q_dw)
    );

    // Surprise stage: round the quotient to whole pixels and subtract.
    always_comb
    begin
        round_sum = {1'b0, q_quot} + (hse_pkg::NUM_W+1)'(32);
        pred      = round_sum[hse_pkg::NUM_W:6];
        s_next    = $signed({{(hse_pkg::S_W-hse_pkg::DW_W){1'b0}}, q_dw})
                    - $signed({1'b0, pred});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    // Encode stage: pick the code length by the range of the surprise value and queue the bytes.
    always_comb
    begin
        short_val = s_reg + hse_pkg::SHORT_BIAS;
        pos_val   = s_reg - hse_pkg::POS_LO;
        neg_val   = -(s_reg + hse_pkg::NEG_BIAS);
        long_val  = -(s_reg + hse_pkg::LONG_BIAS);
        wr        = '0;
        if (s_valid_reg)
        begin
            priority if (s_reg >= hse_pkg::SHORT_LO && s_reg <= hse_pkg::SHORT_HI)
            begin
                wr.count   = 2'd1;
                wr.item[0] = '{code_byte: short_val[7:0], last_byte: 1'b1};
            end
            else if (s_reg >= hse_pkg::POS_LO && s_reg <= hse_pkg::POS_HI)
            begin
                wr.count   = 2'd2;
                wr.item[0] = '{code_byte: hse_pkg::POS_BASE + {6'b0, pos_val[9:8]},
                               last_byte: 1'b0};
                wr.item[1] = '{code_byte: pos_val[7:0], last_byte: 1'b1};
            end
            else if (s_reg >= hse_pkg::NEG_LO && s_reg <= hse_pkg::NEG_HI)
            begin
                wr.count   = 2'd2;
                wr.item[0] = '{code_byte: hse_pkg::NEG_CODE, last_byte: 1'b0};
                wr.item[1] = '{code_byte: neg_val[7:0], last_byte: 1'b1};
            end
            else if (s_reg <= hse_pkg::LONG_HI)
            begin
                wr.count   = 2'd3;
                wr.item[0] = '{code_byte: hse_pkg::LONG_CODE, last_byte: 1'b0};
                wr.item[1] = '{code_byte: long_val[15:8], last_byte: 1'b0};
                wr.item[2] = '{code_byte: long_val[7:0], last_byte: 1'b1};
            end
            else
            begin
                wr.count   = 2'd1;
                wr.item[0] = '{code_byte: '0, last_byte: 1'b1};
            end
        end
    end

    hse_byte_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .pop       (pop),
        .out_valid (result_valid),
        .out_item  (result)
    );

    // Each request reserves three queue bytes on entry; unused ones come
    // back when its code is written, the rest as bytes leave the queue.
    always_comb
    begin
        refund      = s_valid_reg ? (2'(hse_pkg::MAX_BYTES) - wr.count) : 2'd0;
        credit_next = credit_reg
                      - (accept ? hse_pkg::CRED_W'(hse_pkg::MAX_BYTES) : '0)
                      + hse_pkg::CRED_W'(pop)
                      + hse_pkg::CRED_W'(refund);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= hse_pkg::CRED_W'(hse_pkg::FIFO_DEPTH);
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

endmodule

`default_nettype wire
